FILE: rtl/core/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// shared widths and sequencer state codes for the fraction reducer
// ----------------------------------------------------------------------------
package frr_pkg;

    // magnitude width of numerator and denominator
    localparam int MAG_WIDTH = 64;

    // divider step counter width, counts MAG_WIDTH-1 down to 0
    localparam int CNT_W = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;

    typedef logic [MAG_WIDTH-1:0] mag_t;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_GCD_CHECK = 6'b000010,
        S_GCD_DIV   = 6'b000100,
        S_DIV_NUM   = 6'b001000,
        S_DIV_DEN   = 6'b010000,
        S_RESULT    = 6'b100000
    } seq_state_t;

endpackage

FILE: rtl/core/frr_divider.sv
// ----------------------------------------------------------------------------
// frr_divider
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module frr_divider
    import frr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  mag_t dividend,
    input  mag_t divisor,
    output logic done,
    output mag_t quotient,
    output mag_t remainder
);

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mag_t             rem_reg, rem_next;
    mag_t             quo_reg, quo_next;
    mag_t             div_reg, div_next;

    logic [MAG_WIDTH:0] shifted;
    logic [MAG_WIDTH:0] div_ext;
    logic [MAG_WIDTH:0] diff;
    logic               ge;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[MAG_WIDTH-1]};
        div_ext = {1'b0, div_reg};
        ge      = (shifted >= div_ext);
        diff    = shifted - div_ext;
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(MAG_WIDTH - 1);
            rem_next    = '0;
            quo_next    = dividend;
            div_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next = ge ? diff[MAG_WIDTH-1:0] : shifted[MAG_WIDTH-1:0];
            quo_next = {quo_reg[MAG_WIDTH-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/core/fraction_reducer_64.sv
// ----------------------------------------------------------------------------
// fraction_reducer_64
// reduces one signed fraction to lowest terms with euclid's remainder loop
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  --------------------------------
// command   in         start & !busy          num_magnitude, num_negative,
//                                             den_magnitude, den_negative
// result    out        done (one-cycle pulse) reduced_num, reduced_den,
//                                             result_negative
//
// one transfer in gives exactly one transfer out; busy stays high meanwhile
// sequence: euclid remainder steps on the shared bit-serial divider, up to about
//   93 steps at 64 bits, then numerator and denominator are each divided by
//   the gcd when the gcd is above 1
// reset: asynchronous active-low rst_n returns the sequencer to idle
// stalls: none on the result side, done is never held off by the receiver
//
module fraction_reducer_64
    import frr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  mag_t num_magnitude,
    input  logic num_negative,
    input  mag_t den_magnitude,
    input  logic den_negative,
    output logic done,
    output mag_t reduced_num,
    output mag_t reduced_den,
    output logic result_negative
);

    seq_state_t state_reg, state_next;

    // working registers: euclid pair (x, y) and the fraction itself
    mag_t x_reg, x_next;
    mag_t y_reg, y_next;
    mag_t n_reg, n_next;
    mag_t d_reg, d_next;
    logic neg_reg, neg_next;

    // shared divider request
    logic div_start;
    mag_t div_dividend;
    mag_t div_divisor;
    logic div_done;
    mag_t div_quo;
    mag_t div_rem;

    logic accept;

    assign accept = start && (state_reg == S_IDLE);

    frr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        neg_next     = neg_reg;
        div_start    = 1'b0;
        div_dividend = x_reg;
        div_divisor  = y_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next     = num_magnitude;
                    d_next     = den_magnitude;
                    x_next     = num_magnitude;
                    y_next     = den_magnitude;
                    neg_next   = num_negative ^ den_negative;
                    state_next = S_GCD_CHECK;
                end
            end
            S_GCD_CHECK:
            begin
                if (y_reg == '0)
                begin
                    // x now holds the gcd
                    if (x_reg > MAG_WIDTH'(1))
                    begin
                        div_start    = 1'b1;
                        div_dividend = n_reg;
                        div_divisor  = x_reg;
                        state_next   = S_DIV_NUM;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    // next remainder step x mod y
                    div_start  = 1'b1;
                    state_next = S_GCD_DIV;
                end
            end
            S_GCD_DIV:
            begin
                if (div_done)
                begin
                    x_next     = y_reg;
                    y_next     = div_rem;
                    state_next = S_GCD_CHECK;
                end
            end
            S_DIV_NUM:
            begin
                if (div_done)
                begin
                    n_next       = div_quo;
                    div_start    = 1'b1;
                    div_dividend = d_reg;
                    div_divisor  = x_reg;
                    state_next   = S_DIV_DEN;
                end
            end
            S_DIV_DEN:
            begin
                if (div_done)
                begin
                    d_next     = div_quo;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // result transfer is shown for the single cycle spent in the result state
    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_RESULT);
    assign reduced_num     = n_reg;
    assign reduced_den     = d_reg;
    assign result_negative = neg_reg;

`ifndef SYNTHESIS
    // an accepted command keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // a result transfer returns the block to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block stayed busy after result");

    // a zero denominator only survives as 0/0 or 1/0
    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (reduced_den == '0)) |-> (reduced_num <= MAG_WIDTH'(1)))
        else $error("zero denominator left unreduced");

    // a zero numerator only survives as 0/0 or 0/1
    a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (reduced_num == '0)) |-> (reduced_den <= MAG_WIDTH'(1)))
        else $error("zero numerator left unreduced");
`endif

endmodule
